// ===== rtl/core/sck_pkg.sv =====
// Shared constants and word types for the 2D cubic spline SPH kernel.
// Used by sck_div, sck_poly, sck_grad and the top level; no dependencies.
package sck_pkg;

    localparam logic [63:0] KS        = 64'd8388258580802726470;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [31:0] TWO_Q30   = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
    localparam int          DIV_STEPS = 64;

    typedef struct packed {
        logic               kill;
        logic               far;
        logic               rz;
        logic [31:0]        r;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } sck_ftag_t;

    typedef struct packed {
        logic               kill;
        logic               rz;
        logic [31:0]        weight;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } sck_ptag_t;

    typedef struct packed {
        sck_ptag_t p;
        logic      ovf;
    } sck_gtag_t;

endpackage

// ===== rtl/core/sck_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, 64-bit quotient.
// Depends on sck_pkg for the stage count.
module sck_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [63:0] den,
    output logic [63:0] quot
);

    localparam int LAST = sck_pkg::DIV_STEPS - 1;

    logic [63:0] rem_reg [LAST];
    logic [63:0] den_reg [LAST];
    logic [63:0] lq_reg  [sck_pkg::DIV_STEPS];

    for (genvar i = 0; i < sck_pkg::DIV_STEPS; i++)
    begin : g_step
        logic [63:0] rem_in;
        logic [63:0] lq_in;
        logic [63:0] den_in;
        logic [64:0] trial;
        logic        take;

        if (i == 0)
        begin : g_first
            assign rem_in = num_hi;
            assign lq_in  = num_lo;
            assign den_in = den;
        end
        else
        begin : g_chain
            assign rem_in = rem_reg[i-1];
            assign lq_in  = lq_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, lq_in[63]};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lq_reg[i] <= {lq_in[62:0], take};
            end
        end

        if (i < LAST)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= take ? 64'(trial - {1'b0, den_in}) : trial[63:0];
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign quot = lq_reg[LAST];

endmodule

// ===== rtl/core/sck_poly.sv =====
// Kernel polynomial stages: powers of q or (2-q), weight product, gradient numerator.
// Depends on sck_pkg; four register stages.
module sck_poly (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       h,
    input  logic [63:0]       s32,
    input  logic [31:0]       q,
    input  sck_pkg::sck_ftag_t tag_in,
    output logic              out_valid,
    output logic [95:0]       num,
    output logic [63:0]       rh,
    output sck_pkg::sck_ptag_t tag_out
);

    logic               a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    sck_pkg::sck_ftag_t a_tag_reg, b_tag_reg, c_tag_reg;
    sck_pkg::sck_ptag_t d_tag_reg;
    logic [63:0]        a_s_reg, b_s_reg;
    logic [31:0]        a_q_reg;
    logic [31:0]        a_sq_reg, a_gn_reg;
    logic [63:0]        a_rh_reg, b_rh_reg, c_rh_reg, d_rh_reg;
    logic [31:0]        b_pb_reg, b_kg_reg;
    logic [63:0]        c_wlo_reg, c_whi_reg, c_nlo_reg, c_nhi_reg;
    logic [95:0]        d_num_reg;

    logic [31:0] a_d, a_m, a_gfac;
    logic [33:0] a_q3;
    logic [63:0] a_sq_full, a_gn_full;
    logic [31:0] b_d, b_fac;
    logic [63:0] b_pb_full;
    logic [33:0] b_kg_full;
    logic [33:0] c_pb3;
    logic [31:0] c_f, c_wfac;
    logic [95:0] d_wprod, d_nprod;
    logic        d_wsat;
    logic [31:0] d_wval, d_weight;

    // stage A: square of q or (2-q), near-side gradient factor, r*h
    always_comb
    begin
        a_d       = sck_pkg::TWO_Q30 - q;
        a_m       = tag_in.far ? a_d : q;
        a_sq_full = {32'd0, a_m} * {32'd0, a_m};
        a_q3      = ({2'b00, q} << 1) + {2'b00, q};
        a_gfac    = 32'({2'b00, sck_pkg::ONE_Q30} - (a_q3 >> 2));
        a_gn_full = {32'd0, q} * {32'd0, a_gfac};
    end

    // stage B: cube term or near-side t, scaled gradient term
    always_comb
    begin
        b_d       = sck_pkg::TWO_Q30 - a_q_reg;
        b_fac     = a_tag_reg.far ? b_d : (sck_pkg::ONE_Q30 - {1'b0, a_q_reg[31:1]});
        b_pb_full = {32'd0, a_sq_reg} * {32'd0, b_fac};
        if (a_tag_reg.far)
        begin
            b_kg_full = ({2'b00, a_sq_reg} << 1) + {2'b00, a_sq_reg};
        end
        else
        begin
            b_kg_full = ({2'b00, a_gn_reg} << 3) + ({2'b00, a_gn_reg} << 2);
        end
    end

    // stage C: partial products of s with the weight factor and the gradient term
    always_comb
    begin
        c_pb3  = ({2'b00, b_pb_reg} << 1) + {2'b00, b_pb_reg};
        c_f    = 32'({2'b00, sck_pkg::ONE_Q30} - (c_pb3 >> 1));
        c_wfac = b_tag_reg.far ? b_pb_reg : c_f;
    end

    // stage D: combine partial products, saturate weight, zero it for killed pairs
    always_comb
    begin
        d_wprod = {c_whi_reg, 32'd0} + {32'd0, c_wlo_reg};
        d_nprod = {c_nhi_reg, 32'd0} + {32'd0, c_nlo_reg};
        if (c_tag_reg.far)
        begin
            d_wsat = |d_wprod[95:80];
            d_wval = d_wprod[79:48];
        end
        else
        begin
            d_wsat = |d_wprod[95:78];
            d_wval = d_wprod[77:46];
        end
        if (c_tag_reg.kill)
        begin
            d_weight = 32'd0;
        end
        else if (d_wsat)
        begin
            d_weight = 32'hFFFF_FFFF;
        end
        else
        begin
            d_weight = d_wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_tag_reg <= tag_in;
            a_s_reg   <= s32;
            a_q_reg   <= q;
            a_sq_reg  <= a_sq_full[61:30];
            a_gn_reg  <= a_gn_full[61:30];
            a_rh_reg  <= {32'd0, tag_in.r} * {32'd0, h};

            b_tag_reg <= a_tag_reg;
            b_s_reg   <= a_s_reg;
            b_pb_reg  <= b_pb_full[61:30];
            b_kg_reg  <= b_kg_full[31:0];
            b_rh_reg  <= a_rh_reg;

            c_tag_reg <= b_tag_reg;
            c_wlo_reg <= {32'd0, b_s_reg[31:0]} * {32'd0, c_wfac};
            c_whi_reg <= {32'd0, b_s_reg[63:32]} * {32'd0, c_wfac};
            c_nlo_reg <= {32'd0, b_s_reg[31:0]} * {32'd0, b_kg_reg};
            c_nhi_reg <= {32'd0, b_s_reg[63:32]} * {32'd0, b_kg_reg};
            c_rh_reg  <= b_rh_reg;

            d_tag_reg.kill   <= c_tag_reg.kill;
            d_tag_reg.rz     <= c_tag_reg.rz;
            d_tag_reg.weight <= d_weight;
            d_tag_reg.x      <= c_tag_reg.x;
            d_tag_reg.y      <= c_tag_reg.y;
            d_tag_reg.z      <= c_tag_reg.z;
            d_num_reg        <= d_nprod;
            d_rh_reg         <= c_rh_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign num       = d_num_reg;
    assign rh        = d_rh_reg;
    assign tag_out   = d_tag_reg;

endmodule

// ===== rtl/core/sck_grad.sv =====
// Gradient back end: divide by r*h, scale each offset component, saturate; zero for killed or r = 0 pairs.
// Depends on sck_pkg and sck_div.
module sck_grad (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [95:0]        num,
    input  logic [63:0]        rh,
    input  sck_pkg::sck_ptag_t tag_in,
    output logic               out_valid,
    output logic [31:0]        weight,
    output logic signed [31:0] grad_x,
    output logic signed [31:0] grad_y,
    output logic signed [31:0] grad_z
);

    localparam int LAST = sck_pkg::DIV_STEPS - 1;

    logic [sck_pkg::DIV_STEPS-1:0] v_reg;
    sck_pkg::sck_gtag_t            t_reg [sck_pkg::DIV_STEPS];
    sck_pkg::sck_gtag_t            t_in;
    logic [63:0]                   quot;
    logic [63:0]                   u;
    logic [31:0]                   comp [3];

    logic               m_valid_reg;
    sck_pkg::sck_ptag_t m_tag_reg;
    logic [63:0]        m_lo_reg [3];
    logic [63:0]        m_hi_reg [3];
    logic               m_neg_reg [3];

    logic               o_valid_reg;
    logic [31:0]        o_weight_reg;
    logic [31:0]        o_grad_reg [3];

    always_comb
    begin
        t_in.p   = tag_in;
        t_in.ovf = {32'd0, num[95:64]} >= rh;
    end

    sck_div u_div (
        .clk    (clk),
        .en     (en),
        .num_hi ({32'd0, num[95:64]}),
        .num_lo (num[63:0]),
        .den    (rh),
        .quot   (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg       <= {v_reg[LAST-1:0], in_valid};
            m_valid_reg <= v_reg[LAST];
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= t_in;
            for (int i = 1; i < sck_pkg::DIV_STEPS; i++)
            begin
                t_reg[i] <= t_reg[i-1];
            end
            m_tag_reg    <= t_reg[LAST].p;
            o_weight_reg <= m_tag_reg.weight;
        end
    end

    assign u       = t_reg[LAST].ovf ? '1 : quot;
    assign comp[0] = t_reg[LAST].p.x;
    assign comp[1] = t_reg[LAST].p.y;
    assign comp[2] = t_reg[LAST].p.z;

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic        neg;
        logic [31:0] xm;
        logic [95:0] full;
        logic [63:0] mag64;
        logic [31:0] limit;
        logic [31:0] mag;
        logic [31:0] res;

        assign neg = comp[k][31];
        assign xm  = neg ? (32'd0 - comp[k]) : comp[k];

        always_comb
        begin
            full  = {m_hi_reg[k], 32'd0} + {32'd0, m_lo_reg[k]};
            mag64 = full[95:32];
            limit = m_neg_reg[k] ? sck_pkg::POS_LIMIT : sck_pkg::NEG_LIMIT;
            mag   = (mag64 > {32'd0, limit}) ? limit : mag64[31:0];
            if (m_tag_reg.kill || m_tag_reg.rz)
            begin
                res = 32'd0;
            end
            else
            begin
                res = m_neg_reg[k] ? mag : (32'd0 - mag);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_lo_reg[k]   <= {32'd0, u[31:0]} * {32'd0, xm};
                m_hi_reg[k]   <= {32'd0, u[63:32]} * {32'd0, xm};
                m_neg_reg[k]  <= neg;
                o_grad_reg[k] <= res;
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign weight    = o_weight_reg;
    assign grad_x    = o_grad_reg[0];
    assign grad_y    = o_grad_reg[1];
    assign grad_z    = o_grad_reg[2];

endmodule

// ===== rtl/core/sph_cubic_spline_kernel.sv =====
// Top level of the 2D cubic spline SPH kernel: smoothing length register, front
// dividers, polynomial and gradient pipelines, two-word output queue.
// Depends on sck_pkg, sck_div, sck_poly and sck_grad.
//
// Takes one particle pair per cycle (separation vector and distance r, Q16.16) and
// returns the kernel weight and gradient for smoothing length h. An accepted word
// passes through the 64-stage dividers (s and q in parallel, then the gradient
// divide by r*h) and leaves when the output side is ready. The pipeline advances
// whenever the two-word output queue has room, so input is taken every cycle until
// the queue is full while the output side stalls.
// Write the smoothing length only while no word is in flight.
module sph_cubic_spline_kernel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] offset_x,
    input  logic signed [31:0] offset_y,
    input  logic signed [31:0] offset_z,
    input  logic [31:0]        distance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        weight,
    output logic signed [31:0] grad_x,
    output logic signed [31:0] grad_y,
    output logic signed [31:0] grad_z
);

    localparam int LAST = sck_pkg::DIV_STEPS - 1;

    logic [31:0] smoothing_length_reg;
    logic [63:0] hh_reg;
    logic        ce;

    logic               f_valid_reg;
    sck_pkg::sck_ftag_t f_tag_reg;

    logic [sck_pkg::DIV_STEPS-1:0] v1_reg;
    sck_pkg::sck_ftag_t            t1_reg [sck_pkg::DIV_STEPS];
    logic [63:0]                   s_quot, q_quot;

    logic               p_valid;
    logic [95:0]        p_num;
    logic [63:0]        p_rh;
    sck_pkg::sck_ptag_t p_tag;

    logic               g_valid;
    logic [31:0]        g_weight;
    logic signed [31:0] g_gx, g_gy, g_gz;

    logic [127:0] q_data_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothing_length_reg <= 32'd65536;
            hh_reg               <= 64'h1_0000_0000;
        end
        else
        begin
            if (cfg_we)
            begin
                smoothing_length_reg <= cfg_wdata;
            end
            hh_reg <= {32'd0, smoothing_length_reg} * {32'd0, smoothing_length_reg};
        end
    end

    assign ce       = cnt_reg != 2'd2;
    assign in_ready = ce;

    // front register: range flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            v1_reg      <= '0;
        end
        else if (ce)
        begin
            f_valid_reg <= in_valid;
            v1_reg      <= {v1_reg[LAST-1:0], f_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f_tag_reg.kill <= (smoothing_length_reg == 32'd0)
                              || ({1'b0, distance} > {smoothing_length_reg, 1'b0});
            f_tag_reg.far  <= distance > smoothing_length_reg;
            f_tag_reg.rz   <= distance == 32'd0;
            f_tag_reg.r    <= distance;
            f_tag_reg.x    <= offset_x;
            f_tag_reg.y    <= offset_y;
            f_tag_reg.z    <= offset_z;
            t1_reg[0]      <= f_tag_reg;
            for (int i = 1; i < sck_pkg::DIV_STEPS; i++)
            begin
                t1_reg[i] <= t1_reg[i-1];
            end
        end
    end

    // s = KS / h^2
    sck_div u_div_s (
        .clk    (clk),
        .en     (ce),
        .num_hi (64'd0),
        .num_lo (sck_pkg::KS),
        .den    (hh_reg),
        .quot   (s_quot)
    );

    // q = r * 2^30 / h
    sck_div u_div_q (
        .clk    (clk),
        .en     (ce),
        .num_hi (64'd0),
        .num_lo ({2'b00, f_tag_reg.r, 30'd0}),
        .den    ({32'd0, smoothing_length_reg}),
        .quot   (q_quot)
    );

    sck_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ce),
        .in_valid  (v1_reg[LAST]),
        .h         (smoothing_length_reg),
        .s32       (s_quot),
        .q         (q_quot[31:0]),
        .tag_in    (t1_reg[LAST]),
        .out_valid (p_valid),
        .num       (p_num),
        .rh        (p_rh),
        .tag_out   (p_tag)
    );

    sck_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ce),
        .in_valid  (p_valid),
        .num       (p_num),
        .rh        (p_rh),
        .tag_in    (p_tag),
        .out_valid (g_valid),
        .weight    (g_weight),
        .grad_x    (g_gx),
        .grad_y    (g_gy),
        .grad_z    (g_gz)
    );

    // output queue
    assign push = ce && g_valid;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= {g_weight, g_gx, g_gy, g_gz};
        end
    end

    assign out_valid = cnt_reg != 2'd0;
    assign weight    = q_data_reg[rd_ptr_reg][127:96];
    assign grad_x    = q_data_reg[rd_ptr_reg][95:64];
    assign grad_y    = q_data_reg[rd_ptr_reg][63:32];
    assign grad_z    = q_data_reg[rd_ptr_reg][31:0];

endmodule

// ===== rtl/core/sck_chk.sv =====
// Port-level checker for the SPH kernel block, bound to the top level.
// Depends only on the top level's ports.
module sck_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [31:0]        weight,
    input logic signed [31:0] grad_x,
    input logic signed [31:0] grad_y,
    input logic signed [31:0] grad_z
);

    logic [7:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pend_next = pend_reg + 8'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pend_next = pend_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 8'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 8'd0)
        else $error("result word without an accepted input word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input held off while no result is waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(weight) && $stable(grad_x)
                                    && $stable(grad_y) && $stable(grad_z))
        else $error("result word changed while stalled");

endmodule

bind sph_cubic_spline_kernel sck_chk u_sck_chk (.*);
